@@ hdl/sm83_alu_with_flags_macros.svh @@
// Assertion helpers for the SM83 ALU block.
// Each one expects clk and arst_n in scope.
`ifndef SM83_ALU_WITH_FLAGS_MACROS_SVH
`define SM83_ALU_WITH_FLAGS_MACROS_SVH

// same-cycle implication
`define SM83_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SM83_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sm83_pkg.sv @@
package sm83_pkg;

	localparam int unsigned OpW = 5;
	localparam int unsigned WordW = 16;
	localparam int unsigned ByteW = 8;
	localparam int unsigned BitIdxW = 3;

	typedef logic [OpW-1:0] sm83_op_t;

	localparam sm83_op_t OP_ADD       = 5'd0;
	localparam sm83_op_t OP_ADC       = 5'd1;
	localparam sm83_op_t OP_SUB       = 5'd2;
	localparam sm83_op_t OP_SBC       = 5'd3;
	localparam sm83_op_t OP_AND       = 5'd4;
	localparam sm83_op_t OP_OR        = 5'd5;
	localparam sm83_op_t OP_XOR       = 5'd6;
	localparam sm83_op_t OP_CP        = 5'd7;
	localparam sm83_op_t OP_INC8      = 5'd8;
	localparam sm83_op_t OP_DEC8      = 5'd9;
	localparam sm83_op_t OP_RLC       = 5'd10;
	localparam sm83_op_t OP_RL        = 5'd11;
	localparam sm83_op_t OP_RRC       = 5'd12;
	localparam sm83_op_t OP_RR        = 5'd13;
	localparam sm83_op_t OP_SLA       = 5'd14;
	localparam sm83_op_t OP_SRA       = 5'd15;
	localparam sm83_op_t OP_SRL       = 5'd16;
	localparam sm83_op_t OP_SWAP      = 5'd17;
	localparam sm83_op_t OP_BIT       = 5'd18;
	localparam sm83_op_t OP_SET       = 5'd19;
	localparam sm83_op_t OP_RES       = 5'd20;
	localparam sm83_op_t OP_DAA       = 5'd21;
	localparam sm83_op_t OP_CPL       = 5'd22;
	localparam sm83_op_t OP_SCF       = 5'd23;
	localparam sm83_op_t OP_CCF       = 5'd24;
	localparam sm83_op_t OP_ADD16     = 5'd25;
	localparam sm83_op_t OP_ADD_SP_E8 = 5'd26;
	localparam sm83_op_t OP_INC16     = 5'd27;
	localparam sm83_op_t OP_DEC16     = 5'd28;

	// Z N H C, same order as the F register's upper nibble
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} sm83_flags_t;

	localparam sm83_flags_t FlagsReset = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

@@ hdl/sm83_alu_with_flags.sv @@
// SM83 ALU with its Z/N/H/C flag register.
// Each operation passes through the input register, then the result register, before result valid.
// Throughput: one operation per cycle while res_stall is low; flags from one operation feed the next with no bubble.
// Reset (arst_n low, asynchronous): flags cleared, both stages emptied.
`include "sm83_alu_with_flags_macros.svh"

module sm83_alu_with_flags (
	input  logic                           clk,
	input  logic                           arst_n,
	// operation channel
	input  logic                           op_valid,
	output logic                           op_stall,
	input  logic [sm83_pkg::OpW-1:0]       opcode,
	input  logic [sm83_pkg::WordW-1:0]     operand_a,
	input  logic [sm83_pkg::WordW-1:0]     operand_b,
	input  logic [sm83_pkg::BitIdxW-1:0]   bit_index,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [sm83_pkg::WordW-1:0]     result,
	output logic                           write_result,
	output logic                           zero_out,
	output logic                           subtract_out,
	output logic                           half_carry_out,
	output logic                           carry_out
);
	import sm83_pkg::*;

	// ------------------------------------------------------------------
	// Handshake
	// Stage 1 holds the accepted operation. It advances into the result
	// register whenever that register is empty or being drained. The flag
	// register is updated on the same edge, so the operation right behind
	// always sees the flags of the one before it.
	// ------------------------------------------------------------------
	logic s1_valid;
	logic s1_adv;
	logic op_xfer;
	logic res_valid_q;

	assign s1_adv   = s1_valid && !(res_valid_q && res_stall);
	assign op_stall = s1_valid && res_valid_q && res_stall;
	assign op_xfer  = op_valid && !op_stall;

	// stage 1 payload
	sm83_op_t               op_s1;
	logic [WordW-1:0]       opa_s1;
	logic [WordW-1:0]       opb_s1;
	logic [BitIdxW-1:0]     bidx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (op_xfer) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_xfer) begin
			op_s1   <= opcode;
			opa_s1  <= operand_a;
			opb_s1  <= operand_b;
			bidx_s1 <= bit_index;
		end
	end

	// ------------------------------------------------------------------
	// Execute: one pass of combinational logic on the stage 1 operands
	// and the current flags.
	// ------------------------------------------------------------------
	sm83_flags_t flag_q;
	sm83_flags_t flags_nxt;
	logic [WordW-1:0] res_nxt;
	logic             wr_nxt;

	logic [ByteW-1:0] a8;
	logic [ByteW-1:0] b8;
	logic             ci;
	logic             use_ci;
	logic [ByteW:0]   sum9;
	logic [4:0]       hsum5;
	logic [ByteW:0]   dif9;
	logic [4:0]       hdif5;
	logic [ByteW:0]   sp_sum9;
	logic [4:0]       sp_hsum5;
	logic [WordW:0]   sum17;
	logic [12:0]      hsum13;
	logic [ByteW-1:0] bit_mask;
	logic [ByteW-1:0] daa_r;
	logic             daa_c;
	logic [ByteW-1:0] r8;

	assign a8       = opa_s1[ByteW-1:0];
	assign b8       = opb_s1[ByteW-1:0];
	assign ci       = flag_q.c;
	assign use_ci   = ci && ((op_s1 == OP_ADC) || (op_s1 == OP_SBC));

	// 8-bit adder / subtractor with nibble carry
	assign sum9  = {1'b0, a8} + {1'b0, b8} + {{ByteW{1'b0}}, use_ci};
	assign hsum5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, use_ci};
	assign dif9  = {1'b0, a8} - {1'b0, b8} - {{ByteW{1'b0}}, use_ci};
	assign hdif5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, use_ci};

	// SP + e8: H and C come from the unsigned low-byte add
	assign sp_sum9  = {1'b0, a8} + {1'b0, b8};
	assign sp_hsum5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};

	// 16-bit add, H out of bit 11
	assign sum17  = {1'b0, opa_s1} + {1'b0, opb_s1};
	assign hsum13 = {1'b0, opa_s1[11:0]} + {1'b0, opb_s1[11:0]};

	assign bit_mask = ByteW'(1) << bidx_s1;

	// decimal adjust
	always_comb begin
		daa_r = a8;
		daa_c = flag_q.c;
		if (!flag_q.n) begin
			if (flag_q.c || (a8 > 8'h99)) begin
				daa_r = daa_r + 8'h60;
				daa_c = 1'b1;
			end
			if (flag_q.h || (a8[3:0] > 4'h9)) begin
				daa_r = daa_r + 8'h06;
			end
		end else begin
			if (flag_q.c) begin
				daa_r = daa_r - 8'h60;
			end
			if (flag_q.h) begin
				daa_r = daa_r - 8'h06;
			end
		end
	end

	always_comb begin
		r8        = '0;
		res_nxt   = '0;
		wr_nxt    = 1'b1;
		flags_nxt = flag_q;
		case (op_s1)
			OP_ADD, OP_ADC: begin
				r8        = sum9[ByteW-1:0];
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: hsum5[4], c: sum9[ByteW]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				r8        = dif9[ByteW-1:0];
				flags_nxt = '{z: (r8 == '0), n: 1'b1, h: hdif5[4], c: dif9[ByteW]};
				if (op_s1 == OP_CP) begin
					r8     = '0;
					wr_nxt = 1'b0;
				end
			end
			OP_AND: begin
				r8        = a8 & b8;
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			OP_OR: begin
				r8        = a8 | b8;
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_XOR: begin
				r8        = a8 ^ b8;
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_INC8: begin
				r8        = a8 + 8'd1;
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: (a8[3:0] == 4'hf), c: flag_q.c};
			end
			OP_DEC8: begin
				r8        = a8 - 8'd1;
				flags_nxt = '{z: (r8 == '0), n: 1'b1, h: (a8[3:0] == 4'h0), c: flag_q.c};
			end
			OP_RLC: begin
				r8        = {a8[6:0], a8[7]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[7]};
			end
			OP_RL: begin
				r8        = {a8[6:0], ci};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[7]};
			end
			OP_RRC: begin
				r8        = {a8[0], a8[7:1]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[0]};
			end
			OP_RR: begin
				r8        = {ci, a8[7:1]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[0]};
			end
			OP_SLA: begin
				r8        = {a8[6:0], 1'b0};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[7]};
			end
			OP_SRA: begin
				r8        = {a8[7], a8[7:1]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[0]};
			end
			OP_SRL: begin
				r8        = {1'b0, a8[7:1]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[0]};
			end
			OP_SWAP: begin
				r8        = {a8[3:0], a8[7:4]};
				flags_nxt = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_BIT: begin
				wr_nxt    = 1'b0;
				flags_nxt = '{z: !a8[bidx_s1], n: 1'b0, h: 1'b1, c: flag_q.c};
			end
			OP_SET: begin
				r8 = a8 | bit_mask;
			end
			OP_RES: begin
				r8 = a8 & ~bit_mask;
			end
			OP_DAA: begin
				r8        = daa_r;
				flags_nxt = '{z: (r8 == '0), n: flag_q.n, h: 1'b0, c: daa_c};
			end
			OP_CPL: begin
				r8        = ~a8;
				flags_nxt = '{z: flag_q.z, n: 1'b1, h: 1'b1, c: flag_q.c};
			end
			OP_SCF: begin
				wr_nxt    = 1'b0;
				flags_nxt = '{z: flag_q.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			OP_CCF: begin
				wr_nxt    = 1'b0;
				flags_nxt = '{z: flag_q.z, n: 1'b0, h: 1'b0, c: !flag_q.c};
			end
			OP_ADD16: begin
				res_nxt   = sum17[WordW-1:0];
				flags_nxt = '{z: flag_q.z, n: 1'b0, h: hsum13[12], c: sum17[WordW]};
			end
			OP_ADD_SP_E8: begin
				// offset is sign-extended to 16 bits
				res_nxt   = opa_s1 + {{(WordW-ByteW){b8[ByteW-1]}}, b8};
				flags_nxt = '{z: 1'b0, n: 1'b0, h: sp_hsum5[4], c: sp_sum9[ByteW]};
			end
			OP_INC16: begin
				res_nxt = opa_s1 + WordW'(1);
			end
			OP_DEC16: begin
				res_nxt = opa_s1 - WordW'(1);
			end
			default: begin
				// unused codes: no write, flags untouched
				wr_nxt = 1'b0;
			end
		endcase
		// 8-bit forms return the byte with a zero high byte
		if ((op_s1 != OP_ADD16) && (op_s1 != OP_ADD_SP_E8) &&
		    (op_s1 != OP_INC16) && (op_s1 != OP_DEC16)) begin
			res_nxt = {{(WordW-ByteW){1'b0}}, r8};
		end
	end

	// ------------------------------------------------------------------
	// Flag register and result register
	// ------------------------------------------------------------------
	logic [WordW-1:0] result_q;
	logic             write_q;
	sm83_flags_t      res_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= FlagsReset;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				flag_q      <= flags_nxt;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q    <= res_nxt;
			write_q     <= wr_nxt;
			res_flags_q <= flags_nxt;
		end
	end

	assign res_valid      = res_valid_q;
	assign result         = result_q;
	assign write_result   = write_q;
	assign zero_out       = res_flags_q.z;
	assign subtract_out   = res_flags_q.n;
	assign half_carry_out = res_flags_q.h;
	assign carry_out      = res_flags_q.c;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`SM83_ASSERT_IMP(a_res_flags_match, res_valid_q, res_flags_q == flag_q,
		"shown flags differ from flag register")
	`SM83_ASSERT_NXT(a_flags_hold, !s1_adv, $stable(flag_q),
		"flags changed without an operation retiring")
	`SM83_ASSERT_IMP(a_nowrite_zero, res_valid_q && !write_q, result_q == '0,
		"no-write result is not zero")
	`SM83_ASSERT_IMP(a_stall_full, op_stall, s1_valid && res_valid_q,
		"input stalled with room in the pipe")
	`SM83_ASSERT_NXT(a_adv_fills, s1_adv, res_valid_q,
		"retired operation did not reach the result register")

endmodule
